// ----- rtl/hha_pkg.sv -----
// Shared constants, types and helpers for the hashed histogram accumulator.
package hha_pkg;

    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 1024;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int IDX_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W = 11;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_READ,
        ST_CMP,
        ST_APPEND,
        ST_LINK,
        ST_DONE
    } hha_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch key/delta/bucket
        logic take_head;  // cursor <= bucket head
        logic step;       // last <= cursor, cursor <= link
        logic hit;        // add delta to matched entry
        logic append;     // allocate new entry (or flag drop)
        logic link;       // chain previous tail to new entry
    } hha_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic head_valid;
        logic key_match;
        logic link_valid;
        logic pool_full;
        logic have_last;
    } hha_status_t;

    // negative keys land in bucket 0
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [BKT_W-1:0] b;
        b = key[KEY_W-1] ? '0 : key[BKT_W-1:0];
        return b;
    endfunction

endpackage

// ----- rtl/hashed_histogram_accumulator_core.sv -----
// Each accepted transaction looks up its bucket head, then reads and compares one chain
//   entry at a time; a hit adds the delta, a miss appends a new entry (linked behind the
//   chain's tail, or as the bucket head) or is dropped when the pool is full.
// Throughput: one transaction in flight; the next is taken in the cycle after the result is
//   loaded, later while the output register is still full.
// Reset (aresetn, sync, active low): heads empty, count zero, output empty; pool not cleared.
module hashed_histogram_accumulator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hha_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] key, [63:32] delta
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hha_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] bin_value,
                                                        // [42:32] distinct_count, rest 0
    output logic [hha_pkg::M_TUSER_W-1:0]    m_tuser    // [0] was_new, [1] dropped
);
    import hha_pkg::*;

    hha_cmd_t    cmd;
    hha_status_t status;
    logic        emit;
    logic        out_free;

    logic [VAL_W-1:0] res_value;
    logic             res_was_new;
    logic             res_dropped;
    logic [CNT_W-1:0] res_count;

    // output register: result parks here so the core can take the next transaction
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    hha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .status   (status),
        .cmd      (cmd)
    );

    hha_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_delta    (s_tdata[KEY_W+VAL_W-1:KEY_W]),
        .cmd         (cmd),
        .status      (status),
        .res_value   (res_value),
        .res_was_new (res_was_new),
        .res_dropped (res_dropped),
        .res_count   (res_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {(M_TDATA_W-VAL_W-CNT_W)'(0), res_count, res_value};
            m_tuser_reg <= {res_dropped, res_was_new};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/hha_ctrl.sv -----
// Sequencer for the hash chain walk: accept, head lookup, walk, update/append, emit.
module hha_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 out_free,
    output logic                 emit,
    input  hha_pkg::hha_status_t status,
    output hha_pkg::hha_cmd_t    cmd
);
    import hha_pkg::*;

    hha_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        emit       = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (status.head_valid) begin
                    cmd.take_head = 1'b1;
                    state_next    = ST_READ;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_READ: begin
                // pool read at the cursor is registered here, compared next cycle
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (status.key_match) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                    state_next = status.link_valid ? ST_READ : ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                if (!status.pool_full && status.have_last) begin
                    state_next = ST_LINK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/hha_datapath.sv -----
// Bucket heads, entry pool memories, walk cursor and result registers.
module hha_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [hha_pkg::KEY_W-1:0]   in_key,
    input  logic [hha_pkg::VAL_W-1:0]   in_delta,
    input  hha_pkg::hha_cmd_t           cmd,
    output hha_pkg::hha_status_t        status,
    output logic [hha_pkg::VAL_W-1:0]   res_value,
    output logic                        res_was_new,
    output logic                        res_dropped,
    output logic [hha_pkg::CNT_W-1:0]   res_count
);
    import hha_pkg::*;

    // heads: index in RAM, valid bits in flops
    logic [IDX_W-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_valid_reg;
    logic [IDX_W-1:0] head_rd_reg;

    // pool; link word is {valid, index}
    logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
    logic [VAL_W-1:0] val_mem  [POOL_ENTRIES];
    logic [IDX_W:0]   link_mem [POOL_ENTRIES];
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [IDX_W:0]   link_rd_reg;

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] delta_reg;
    logic [BKT_W-1:0] bucket_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] last_reg;
    logic             have_last_reg;
    logic [CNT_W-1:0] used_reg;

    logic [VAL_W-1:0] value_reg;
    logic             was_new_reg;
    logic             dropped_reg;

    logic [BKT_W-1:0] in_bucket;
    logic [IDX_W-1:0] new_idx;
    logic             pool_full;
    logic [VAL_W-1:0] hit_sum;

    assign in_bucket = bucket_of(in_key);
    assign new_idx   = used_reg[IDX_W-1:0];
    assign pool_full = (used_reg == CNT_W'(POOL_ENTRIES));
    assign hit_sum   = val_rd_reg + delta_reg;

    assign status.head_valid = head_valid_reg[bucket_reg];
    assign status.key_match  = (key_rd_reg == key_reg);
    assign status.link_valid = link_rd_reg[IDX_W];
    assign status.pool_full  = pool_full;
    assign status.have_last  = have_last_reg;

    // head RAM: read addressed by the incoming item, valid in ST_HEAD
    always_ff @(posedge aclk) begin
        head_rd_reg <= head_mem[in_bucket];
        if (cmd.append && !pool_full && !have_last_reg) begin
            head_mem[bucket_reg] <= new_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
        end else if (cmd.append && !pool_full && !have_last_reg) begin
            head_valid_reg[bucket_reg] <= 1'b1;
        end
    end

    // pool RAMs: registered read at the cursor
    always_ff @(posedge aclk) begin
        key_rd_reg  <= key_mem[cur_reg];
        val_rd_reg  <= val_mem[cur_reg];
        link_rd_reg <= link_mem[cur_reg];
        if (cmd.hit) begin
            val_mem[cur_reg] <= hit_sum;
        end
        if (cmd.append && !pool_full) begin
            key_mem[new_idx] <= key_reg;
            val_mem[new_idx] <= delta_reg;
        end
        if (cmd.append && !pool_full) begin
            link_mem[new_idx] <= '0;
        end else if (cmd.link) begin
            // new entry already counted: it sits at used - 1
            link_mem[last_reg] <= {1'b1, cur_reg};
        end
    end

    // item and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg       <= in_key;
            delta_reg     <= in_delta;
            bucket_reg    <= in_bucket;
            have_last_reg <= 1'b0;
        end
        if (cmd.take_head) begin
            cur_reg <= head_rd_reg;
        end else if (cmd.step) begin
            last_reg      <= cur_reg;
            have_last_reg <= 1'b1;
            cur_reg       <= link_rd_reg[IDX_W-1:0];
        end else if (cmd.append && !pool_full) begin
            cur_reg <= new_idx;
        end
        if (cmd.hit) begin
            value_reg   <= hit_sum;
            was_new_reg <= 1'b0;
            dropped_reg <= 1'b0;
        end else if (cmd.append) begin
            value_reg   <= pool_full ? '0 : delta_reg;
            was_new_reg <= !pool_full;
            dropped_reg <= pool_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.append && !pool_full) begin
            used_reg <= used_reg + 1'b1;
        end
    end

    assign res_value   = value_reg;
    assign res_was_new = was_new_reg;
    assign res_dropped = dropped_reg;
    assign res_count   = used_reg;

endmodule

// ----- tb/hha_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the hashed histogram accumulator: predicts every bin update and checks results.
module hha_checker
    import hha_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [VAL_W-1:0] bin_value;
        logic             was_new;
        logic             dropped;
        logic [CNT_W-1:0] distinct_count;
    } bin_update_t;

    // shadow hash table
    logic             head_ok   [BUCKETS];
    logic [IDX_W-1:0] head_at   [BUCKETS];
    logic [KEY_W-1:0] bin_key   [POOL_ENTRIES];
    logic [VAL_W-1:0] bin_total [POOL_ENTRIES];
    logic             next_ok   [POOL_ENTRIES];
    logic [IDX_W-1:0] next_at   [POOL_ENTRIES];
    int unsigned      bins_used;

    bin_update_t expected_updates[$];

    function automatic bin_update_t accumulate_bin(input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] delta);
        bin_update_t      upd;
        logic [BKT_W-1:0] bkt;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] tail;
        logic [IDX_W-1:0] slot;
        int unsigned      steps;
        logic             have_cur;
        logic             have_tail;
        logic             found;
        upd       = '0;
        bkt       = key[KEY_W-1] ? '0 : BKT_W'(key % BUCKETS);
        have_cur  = head_ok[bkt];
        cur       = head_at[bkt];
        have_tail = 1'b0;
        tail      = '0;
        found     = 1'b0;
        steps     = 0;
        while (have_cur && steps < bins_used) begin
            if (bin_key[cur] == key) begin
                found = 1'b1;
                break;
            end
            have_tail = 1'b1;
            tail      = cur;
            have_cur  = next_ok[cur];
            cur       = next_at[cur];
            steps++;
        end
        if (found) begin
            bin_total[cur] = bin_total[cur] + delta;
            upd.bin_value  = bin_total[cur];
        end else if (bins_used >= POOL_ENTRIES) begin
            upd.dropped = 1'b1;
        end else begin
            slot            = bins_used[IDX_W-1:0];
            bin_key[slot]   = key;
            bin_total[slot] = delta;
            next_ok[slot]   = 1'b0;
            next_at[slot]   = '0;
            if (have_tail) begin
                next_ok[tail] = 1'b1;
                next_at[tail] = slot;
            end else begin
                head_ok[bkt] = 1'b1;
                head_at[bkt] = slot;
            end
            bins_used++;
            upd.bin_value = delta;
            upd.was_new   = 1'b1;
        end
        upd.distinct_count = bins_used[CNT_W-1:0];
        return upd;
    endfunction

    always @(posedge aclk) begin
        bin_update_t want;
        if (!aresetn) begin
            for (int i = 0; i < BUCKETS; i++) begin
                head_ok[i] = 1'b0;
                head_at[i] = '0;
            end
            bins_used = 0;
            expected_updates.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_updates.size() == 0) begin
                    $error("result transaction with no update pending");
                    fail_count++;
                end else begin
                    want = expected_updates.pop_front();
                    if (m_tdata[31:0] !== want.bin_value) begin
                        $error("bin_value: expected %0d, got %0d",
                               $signed(want.bin_value), $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.was_new) begin
                        $error("was_new: expected %0d, got %0d", want.was_new, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tdata[42:32] !== want.distinct_count) begin
                        $error("distinct_count: expected %0d, got %0d",
                               want.distinct_count, m_tdata[42:32]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_updates.push_back(accumulate_bin(s_tdata[31:0], s_tdata[63:32]));
        end
        pending = expected_updates.size();
    end

endmodule

// ----- tb/tb_hashed_histogram_accumulator_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the hashed histogram accumulator: stimulus, flow control and verdict.
module tb_hashed_histogram_accumulator_core;
    import hha_pkg::*;

    // longest legal quiet stretch is the held-off receiver (HOLD_OFF_CYCLES) or a
    // long chain walk; this leaves a wide margin over both
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1380;
    localparam int HOLD_OFF_CYCLES = 300;
    // past this many distinct keys new keys get rare; the pool (1024) is full by then
    localparam int FILL_TARGET = 1040;

    // directed transactions: extremes, wrap in both directions, negative keys
    // in bucket 0, and a three-deep chain in bucket 5
    localparam int DIRECTED = 18;
    localparam logic [31:0] DIR_KEY [DIRECTED] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0100, 32'h8000_0000,
        32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0105, 32'h0000_0205,
        32'h0000_0105, 32'h0000_0005, 32'h0000_0205, 32'h7FFF_FFFF,
        32'h5555_5555, 32'h2AAA_AAAA
    };
    localparam logic [31:0] DIR_DELTA [DIRECTED] = '{
        32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h8000_0000,
        32'h0000_0001, 32'h0000_000A, 32'h0000_0014, 32'h0000_001E,
        32'hFFFF_FFEC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;     // [31:0] key, [63:32] delta
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] bin_value, [42:32] distinct_count
    logic [M_TUSER_W-1:0] m_tuser;          // [0] was_new, [1] dropped

    int fail_count;
    int pending;
    int items_in = 0;
    int quiet_cycles = 0;

    // keys offered so far, so the random part can revisit them for hits
    logic [31:0] offered_keys[$];
    bit          key_seen[logic [31:0]];

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    hashed_histogram_accumulator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hha_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one transaction from a falling edge and hold it until accepted.
    // Returns on the falling edge after the handshake with tvalid still high,
    // so back-to-back calls keep the stream dense.
    task automatic offer_bin(input logic [31:0] key, input logic [31:0] delta);
        if (!key_seen.exists(key)) begin
            key_seen[key] = 1'b1;
            offered_keys.push_back(key);
        end
        s_tdata  = {delta, key};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_in++;
        @(negedge aclk);
    endtask

    // Sender: reset, directed part, then bursts of random traffic
    initial begin
        logic [31:0] key;
        logic [31:0] delta;
        int          burst_left;
        int          new_pct;
        int          pick;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED; i++)
            offer_bin(DIR_KEY[i], DIR_DELTA[i]);

        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // mostly new keys until the pool overflows, then mostly revisits
            // plus a trickle of new keys that must be dropped
            new_pct = (key_seen.num() < FILL_TARGET) ? 85 : 20;
            if ($urandom_range(0, 99) < new_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    key = {1'b1, 31'($urandom)};            // negative: bucket 0
                else if (pick < 15)
                    key = {1'b0, 23'($urandom), 8'd7};      // grow one long chain
                else
                    key = {1'b0, 31'($urandom)};
            end else begin
                key = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
            end
            case ($urandom_range(0, 19))
                0:       delta = 32'h7FFF_FFFF;
                1:       delta = 32'h8000_0000;
                2:       delta = 32'hFFFF_FFFF;
                3:       delta = 32'h0000_0000;
                default: delta = $urandom;
            endcase
            offer_bin(key, delta);

            // burst done: drop tvalid for a random gap, then start a new burst;
            // now and then a long burst with no gaps at all
            burst_left--;
            if (burst_left == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
            end
        end
        s_tvalid = 1'b0;

        // drain, then a short tail to catch any stray result
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("hashed_histogram_accumulator_core verification clean");
        else
            $display("hashed_histogram_accumulator_core verification failed");
        $finish;
    end

    // Receiver: segments of differing stall behavior, with one long hold-off
    // early on so the block backs up into its input
    initial begin
        bit held;
        int mode;
        int span;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held && items_in >= 40) begin
                held = 1'b1;
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            for (int c = 0; c < span; c++) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready = 1'b1;                        // always ready
                    1:       m_tready = 1'($urandom_range(0, 1));    // coin flip
                    2:       m_tready = ($urandom_range(0, 3) == 0); // mostly stalled
                    default: m_tready = c[0];                        // alternating ready and stall
                endcase
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("hashed_histogram_accumulator_core verification failed");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
rtl/hha_pkg.sv
rtl/hha_ctrl.sv
rtl/hha_datapath.sv
rtl/hashed_histogram_accumulator_core.sv
tb/hha_checker.sv
tb/tb_hashed_histogram_accumulator_core.sv
